### rtl/c2p_pkg.sv
// Shared constants and types for the chunky-to-planar converter.
package c2p_pkg;

	localparam int MAX_ROW_PIXELS = 4096;
	localparam int MAX_PLANES     = 8;
	localparam int FOUR_PLANES    = 4;
	localparam int GROUP_SIZE     = 16;

	localparam int PIX_W   = 8;
	localparam int WORD_W  = 16;
	localparam int IDX_W   = 3;
	localparam int GRP_W   = $clog2(GROUP_SIZE);
	localparam int COL_W   = $clog2(MAX_ROW_PIXELS);
	localparam int LEN_W   = COL_W + 1;
	localparam int CFG_W   = 13;
	localparam int CIDX_W  = 1;

	localparam logic [IDX_W-1:0] LAST_EIGHT = IDX_W'(MAX_PLANES - 1);
	localparam logic [IDX_W-1:0] LAST_FOUR  = IDX_W'(FOUR_PLANES - 1);

	typedef enum logic [CIDX_W-1:0] {
		REG_EIGHT_PLANES = 1'b0,
		REG_ROW_PIXELS   = 1'b1
	} reg_idx_t;

	typedef logic [MAX_PLANES-1:0][WORD_W-1:0] words_t;

	typedef struct packed {
		logic   fires;
		words_t words;
	} group_t;

endpackage

### rtl/chunky_to_planar_converter.sv
// Top level of the chunky-to-planar converter: configuration, group buffer and output.
//
// Channel   Direction  Request carries
// s_*       in         one chunky pixel
// m_*       out        one plane word with its plane index, tlast on the group's last word
// cfg_*     in         register index and write data
//
// One pixel is taken per cycle; the 16th pixel of a whole group copies all plane
// words into the group buffer, which then delivers one word per cycle while m_tready
// is high (4 or 8 words). A group-closing pixel waits while the buffer still holds
// undelivered words. Reset clears the column, the configuration to its defaults and
// the output valid. Configuration writes are always taken, as cfg_ready is tied high.
module chunky_to_planar_converter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [c2p_pkg::PIX_W-1:0]    s_tdata,   // [7:0] pixel
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [c2p_pkg::WORD_W-1:0]   m_tdata,   // [15:0] plane_word
	output logic [c2p_pkg::IDX_W-1:0]    m_tuser,   // [2:0] plane_index
	output logic                         m_tlast,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [c2p_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [c2p_pkg::CFG_W-1:0]    cfg_data
);

	logic                          eight_q;
	logic [c2p_pkg::CFG_W-1:0]     row_q;
	c2p_pkg::group_t               group;
	c2p_pkg::words_t               hold_q;
	logic [c2p_pkg::IDX_W-1:0]     idx_q;
	logic [c2p_pkg::IDX_W-1:0]     last_q;
	logic                          active_q;
	logic                          take;
	logic                          load;

	assign cfg_ready = 1'b1;
	assign s_tready  = !group.fires || !active_q;
	assign take      = s_tvalid && s_tready;
	assign load      = take && group.fires;

	c2p_gather u_gather (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.pixel      (s_tdata),
		.row_pixels (row_q),
		.group      (group)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eight_q <= 1'b1;
			row_q   <= c2p_pkg::CFG_W'(320);
		end else if (cfg_valid && cfg_ready) begin
			case (c2p_pkg::reg_idx_t'(cfg_index))
				c2p_pkg::REG_EIGHT_PLANES: eight_q <= cfg_data[0];
				c2p_pkg::REG_ROW_PIXELS:   row_q   <= cfg_data;
				default:                   row_q   <= row_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hold_q <= group.words;
			last_q <= eight_q ? c2p_pkg::LAST_EIGHT : c2p_pkg::LAST_FOUR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (active_q && m_tready) begin
			if (idx_q == last_q) begin
				active_q <= 1'b0;
			end
			idx_q <= idx_q + c2p_pkg::IDX_W'(1);
		end
	end

	assign m_tvalid = active_q;
	assign m_tdata  = hold_q[idx_q];
	assign m_tuser  = idx_q;
	assign m_tlast  = (idx_q == last_q);

`ifndef ASSERT_OFF
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (m_tvalid && m_tuser == '0))
		else $error("Group buffer did not present its first word after a load.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !active_q)
		else $error("Group buffer overwritten while words were pending.");

	a_last_plane: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser == c2p_pkg::LAST_FOUR
			|| m_tuser == c2p_pkg::LAST_EIGHT))
		else $error("Group ended on a plane other than the last one.");
`endif

endmodule

### rtl/c2p_gather.sv
// Plane shift words and row column tracking for the chunky-to-planar converter.
module c2p_gather (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [c2p_pkg::PIX_W-1:0]   pixel,
	input  logic [c2p_pkg::CFG_W-1:0]   row_pixels,
	output c2p_pkg::group_t             group
);

	c2p_pkg::words_t                 shift_q;
	logic [c2p_pkg::COL_W-1:0]       col_q;
	logic [c2p_pkg::LEN_W-1:0]       len;
	logic [c2p_pkg::LEN_W-1:0]       whole_end;
	logic [c2p_pkg::LEN_W-1:0]       col_inc;

	always_comb begin
		if (row_pixels == '0) begin
			len = c2p_pkg::LEN_W'(1);
		end else if (row_pixels > c2p_pkg::CFG_W'(c2p_pkg::MAX_ROW_PIXELS)) begin
			len = c2p_pkg::LEN_W'(c2p_pkg::MAX_ROW_PIXELS);
		end else begin
			len = c2p_pkg::LEN_W'(row_pixels);
		end
	end

	assign whole_end = {len[c2p_pkg::LEN_W-1:c2p_pkg::GRP_W], c2p_pkg::GRP_W'(0)};
	assign col_inc   = {1'b0, col_q} + c2p_pkg::LEN_W'(1);

	always_comb begin
		for (int k = 0; k < c2p_pkg::MAX_PLANES; k++) begin
			group.words[k] = {shift_q[k][c2p_pkg::WORD_W-2:0], pixel[k]};
		end
		group.fires = (col_q[c2p_pkg::GRP_W-1:0] == {c2p_pkg::GRP_W{1'b1}})
			&& ({1'b0, col_q} < whole_end);
	end

	always_ff @(posedge clk) begin
		if (take) begin
			shift_q <= group.words;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (take) begin
			if (col_inc >= len) begin
				col_q <= '0;
			end else begin
				col_q <= col_inc[c2p_pkg::COL_W-1:0];
			end
		end
	end

endmodule
